>>> design/idfl_pkg.sv
// ----------------------------------------------------------------------------
// idfl_pkg
// Shared types and constants for the FIFO free-list identifier allocator.
// ----------------------------------------------------------------------------
package idfl_pkg;

  // Identifier space and derived sizes
  localparam int ID_SPACE = 1024;
  localparam int QDEPTH   = ID_SPACE - 1;
  localparam int PTR_W    = $clog2(QDEPTH);
  localparam int QW       = $clog2(ID_SPACE);
  localparam int CNT_W    = $clog2(ID_SPACE);

  // Fixed field widths of the request and response
  localparam int ID_W = 10;
  localparam int ST_W = 3;

  // Request operations
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Response status codes
  localparam logic [ST_W-1:0] ST_ALLOCATED    = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY        = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASED     = 3'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN      = 3'd3;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd4;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] id;
  } idfl_req_t;

  typedef struct packed {
    logic [ID_W-1:0] alloc_id;
    logic [ST_W-1:0] status;
  } idfl_rsp_t;

endpackage

>>> design/id_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// id_free_list_allocator_unit
// Hands out identifiers from a FIFO free list held in a queue memory and
// takes them back, checking a per-identifier free flag held in a flag memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | idfl_req_t (op, id)
//  rsp     | out       | rsp_valid/rsp_stall  | idfl_rsp_t (alloc_id, status)
//
//  Each request is handled as a synchronous read of the queue slot and the
//  flag, then a modify and write-back of the flag and, for a release, of the
//  queue slot at the tail. After reset a clearing pass sets every flag,
//  while req_stall stays high. Queue slots not yet written read as slot+1.
//  A response waits in the output register; the next request is taken
//  meanwhile and only its write-back cycle waits while rsp_stall holds.
//
module id_free_list_allocator_unit
  import idfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  idfl_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output idfl_rsp_t rsp
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Memories
  logic [QW-1:0] queue_mem [QDEPTH];
  logic          flag_mem  [ID_SPACE];

  logic [1:0]       state;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic             tail_wrapped;
  logic [CNT_W-1:0] free_count;
  logic [QW-1:0]    clr_addr;

  idfl_req_t        req_r;
  logic [QW-1:0]    q_rd;
  logic             f_rd;

  logic             accept;
  logic             advance;
  logic [QW-1:0]    got;
  logic [QW-1:0]    rel_idx;
  logic             rel_unknown;
  logic             do_alloc;
  logic             do_release;
  logic [ST_W-1:0]  status_next;
  logic [ID_W-1:0]  alloc_id_next;
  logic             f_we;
  logic [QW-1:0]    f_waddr;
  logic             f_wdata;
  logic [PTR_W-1:0] head_ptr_next;
  logic [PTR_W-1:0] tail_ptr_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign advance   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // Decode the request against the read data
  always_comb begin
    got         = (tail_wrapped || (head_ptr < tail_ptr)) ? q_rd
                                                          : QW'(head_ptr) + QW'(1);
    rel_idx     = QW'(req_r.id);
    rel_unknown = (req_r.id == '0) || (int'(req_r.id) >= ID_SPACE);
    do_alloc    = 1'b0;
    do_release  = 1'b0;
    alloc_id_next = '0;
    if (req_r.op == OP_ALLOC) begin
      if (free_count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        status_next   = ST_ALLOCATED;
        do_alloc      = 1'b1;
        alloc_id_next = ID_W'(got);
      end
    end else begin
      if (rel_unknown) begin
        status_next = ST_UNKNOWN;
      end else if (f_rd || (free_count == CNT_W'(QDEPTH))) begin
        status_next = ST_ALREADY_FREE;
      end else begin
        status_next = ST_RELEASED;
        do_release  = 1'b1;
      end
    end
  end

  // Pointer wrap
  assign head_ptr_next = (head_ptr == PTR_W'(QDEPTH - 1)) ? '0 : head_ptr + PTR_W'(1);
  assign tail_ptr_next = (tail_ptr == PTR_W'(QDEPTH - 1)) ? '0 : tail_ptr + PTR_W'(1);

  // Flag write port: clearing pass, then allocate or release
  always_comb begin
    if (state == S_INIT) begin
      f_we    = 1'b1;
      f_waddr = clr_addr;
      f_wdata = 1'b1;
    end else begin
      f_we    = advance && (do_alloc || do_release);
      f_waddr = do_alloc ? got : rel_idx;
      f_wdata = do_release;
    end
  end

  // Flag memory
  always_ff @(posedge clk) begin
    if (f_we) begin
      flag_mem[f_waddr] <= f_wdata;
    end
    if (accept) begin
      f_rd <= flag_mem[QW'(req.id)];
    end
  end

  // Queue memory
  always_ff @(posedge clk) begin
    if (advance && do_release) begin
      queue_mem[tail_ptr] <= rel_idx;
    end
    if (accept) begin
      q_rd <= queue_mem[head_ptr];
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req;
    end
  end

  // Sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      clr_addr     <= '0;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      tail_wrapped <= 1'b0;
      free_count   <= CNT_W'(QDEPTH);
    end else begin
      case (state)
        S_INIT: begin
          clr_addr <= clr_addr + QW'(1);
          if (clr_addr == QW'(ID_SPACE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (advance) begin
            state <= S_IDLE;
            if (do_alloc) begin
              head_ptr   <= head_ptr_next;
              free_count <= free_count - CNT_W'(1);
            end
            if (do_release) begin
              tail_ptr   <= tail_ptr_next;
              free_count <= free_count + CNT_W'(1);
              if (tail_ptr == PTR_W'(QDEPTH - 1)) begin
                tail_wrapped <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.alloc_id <= alloc_id_next;
      rsp.status   <= status_next;
    end
  end

endmodule
